### rtl/core/jcs_pkg.sv
package jcs_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

    localparam logic STRIP_RESET = 1'b1;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_STR        = 3'd1,
        MODE_STR_ESC    = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4,
        MODE_LINE       = 3'd5
    } mode_t;

    // one result byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    // results of one input byte: cnt of 0, 1 or 2 beats, b0 first
    typedef struct packed {
        logic [1:0] cnt;
        beat_t      b0;
        beat_t      b1;
    } push_t;

    typedef struct packed {
        mode_t mode;
        logic  held;
        push_t push;
    } step_res_t;

endpackage

### rtl/core/jcs_if.sv
interface jcs_in_if;
    import jcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jcs_out_if;
    import jcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface jcs_cfg_if;
    logic valid;
    logic ready;
    logic strip_enable;

    modport source (output valid, output strip_enable, input ready);
    modport sink   (input valid, input strip_enable, output ready);
endinterface

### rtl/core/json_comment_stripper.sv
// Channel | Dir | Payload                   | Transaction
// src     | in  | in_byte[7:0], in_last     | valid && ready
// dst     | out | out_byte[7:0], out_last   | valid && ready
// cfg     | in  | strip_enable              | valid && ready (ready tied high)
//
// One byte per cycle while dst accepts; bytes cross the input register and queue.
// A held slash yields no result, and the byte after it yields two, drained from
// the two-entry output queue; that queue's free space alone sets when src stalls.
// Reset clears the scan mode, the held slash and the queue; strip_enable resets to 1.
// dst stalls back-pressure src through the input register without dropping bytes.
module json_comment_stripper (
    input  logic      clk,
    input  logic      rst_n,
    jcs_in_if.sink    src,
    jcs_out_if.source dst,
    jcs_cfg_if.sink   cfg
);
    import jcs_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    mode_t             mode_reg;
    logic              held_reg;
    logic              strip_reg;
    step_res_t         res;
    logic [1:0]        room;
    logic              advance;
    logic              take;

    assign cfg.ready = 1'b1;

    jcs_step u_step (
        .mode    (mode_reg),
        .held    (held_reg),
        .strip   (strip_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (res)
    );

    // move the registered byte on only when its results fit in the queue
    assign advance   = in_valid_reg && (res.push.cnt <= room);
    assign src.ready = !in_valid_reg || advance;
    assign take      = src.valid && src.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    jcs_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .push    (res.push),
        .room    (room),
        .dst     (dst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_NORMAL;
            held_reg     <= 1'b0;
            strip_reg    <= STRIP_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                mode_reg <= res.mode;
                held_reg <= res.held;
            end
            if (cfg.valid)
                strip_reg <= cfg.strip_enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= src.in_byte;
            in_last_reg <= src.in_last;
        end
    end

endmodule

### rtl/core/jcs_step.sv
module jcs_step (
    input  jcs_pkg::mode_t             mode,
    input  logic                       held,
    input  logic                       strip,
    input  logic [jcs_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    output jcs_pkg::step_res_t         res
);
    import jcs_pkg::*;

    function automatic mode_t string_next(input logic [BYTE_W-1:0] b);
        mode_t m;
        if (b inside {CH_QUOTE, CH_NL, CH_NUL})
            m = MODE_NORMAL;
        else if (b == CH_BSLASH)
            m = MODE_STR_ESC;
        else
            m = MODE_STR;
        return m;
    endfunction

    beat_t pass_beat;
    beat_t space_beat;

    assign pass_beat  = '{data: in_byte, last: in_last};
    assign space_beat = '{data: CH_SPACE, last: in_last};

    always_comb
    begin
        res.mode     = mode;
        res.held     = held;
        res.push.cnt = 2'd1;
        res.push.b0  = pass_beat;
        res.push.b1  = pass_beat;

        if (!strip)
        begin
            // flush a held slash, then pass the byte
            if (held)
            begin
                res.push.cnt = 2'd2;
                res.push.b0  = '{data: CH_SLASH, last: 1'b0};
            end
            res.mode = MODE_NORMAL;
            res.held = 1'b0;
        end
        else
        begin
            case (mode)
                MODE_STR:
                begin
                    res.mode = string_next(in_byte);
                end
                MODE_STR_ESC:
                begin
                    if (in_byte inside {CH_QUOTE, CH_BSLASH})
                        res.mode = MODE_STR;
                    else
                        res.mode = string_next(in_byte);
                end
                MODE_BLOCK, MODE_BLOCK_STAR:
                begin
                    if (in_byte == CH_NUL)
                        res.mode = MODE_NORMAL;
                    else
                    begin
                        if (in_byte == CH_STAR)
                            res.mode = MODE_BLOCK_STAR;
                        else if (mode == MODE_BLOCK_STAR && in_byte == CH_SLASH)
                            res.mode = MODE_NORMAL;
                        else
                            res.mode = MODE_BLOCK;
                        res.push.b0 = space_beat;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte inside {CH_NL, CH_NUL})
                        res.mode = MODE_NORMAL;
                    else
                        res.push.b0 = space_beat;
                end
                default:
                begin
                    res.mode = (in_byte == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
                    if (held)
                    begin
                        res.held     = 1'b0;
                        res.push.cnt = 2'd2;
                        if (in_byte inside {CH_STAR, CH_SLASH})
                        begin
                            // comment opener: blank both bytes
                            res.mode    = (in_byte == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                            res.push.b0 = '{data: CH_SPACE, last: 1'b0};
                            res.push.b1 = space_beat;
                        end
                        else
                        begin
                            res.push.b0 = '{data: CH_SLASH, last: 1'b0};
                        end
                    end
                    else if (in_byte == CH_SLASH && !in_last)
                    begin
                        // hold the slash for one byte of lookahead
                        res.held     = 1'b1;
                        res.push.cnt = 2'd0;
                    end
                end
            endcase
        end

        if (in_last)
        begin
            res.mode = MODE_NORMAL;
            res.held = 1'b0;
        end
    end

endmodule

### rtl/core/jcs_out_fifo.sv
module jcs_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_en,
    input  jcs_pkg::push_t             push,
    output logic [1:0]                 room,
    jcs_out_if.source                  dst
);
    import jcs_pkg::*;

    beat_t      slot_reg [2];
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    logic [1:0] push_n;
    logic       wr_ptr;
    logic [1:0] wr_sum;

    assign pop    = dst.valid && dst.ready;
    assign push_n = push_en ? push.cnt : 2'd0;
    // free slots once this cycle's pop is taken into account
    assign room   = 2'd2 - count_reg + {1'b0, pop};
    assign wr_sum = {1'b0, rd_ptr_reg} + count_reg;
    assign wr_ptr = wr_sum[0];

    assign dst.valid    = (count_reg != 2'd0);
    assign dst.out_byte = slot_reg[rd_ptr_reg].data;
    assign dst.out_last = slot_reg[rd_ptr_reg].last;

    always_comb
    begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg - {1'b0, pop} + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            slot_reg[wr_ptr] <= push.b0;
        if (push_n == 2'd2)
            slot_reg[~wr_ptr] <= push.b1;
    end

endmodule

### dv/json_comment_stripper_test.sv
module json_comment_stripper_test;
    import jcs_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int N_SCRIPT = 27;
    localparam int N_PHASES = 5;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              typed;
        logic [BYTE_W-1:0] want_data;
        logic              want_last;
    } row_t;

    logic clk;
    logic rst_n;

    jcs_in_if  src_if();
    jcs_out_if dst_if();
    jcs_cfg_if cfg_if();

    json_comment_stripper u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .dst   (dst_if),
        .cfg   (cfg_if)
    );

    // predictor state
    logic  strip_on;
    mode_t mode_now;
    logic  slash_pending;

    beat_t clean_q[$];
    beat_t text_q[$];

    int errors;
    int bytes_sent;
    int beats_checked;
    int strip_writes;
    int hold_count;
    int drain_pauses;
    int burst_left;
    int idle_cycles;
    bit hold_req;

    row_t script [N_SCRIPT];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic emit(input logic [BYTE_W-1:0] b, input logic l);
        beat_t nb;
        nb.data = b;
        nb.last = l;
        clean_q.insert(clean_q.size(), nb);
    endtask

    function automatic mode_t str_next(input logic [BYTE_W-1:0] b);
        if (b == CH_QUOTE || b == CH_NL || b == CH_NUL)
        begin
            return MODE_NORMAL;
        end
        if (b == CH_BSLASH)
        begin
            return MODE_STR_ESC;
        end
        return MODE_STR;
    endfunction

    // Work out the bytes one input byte releases and append them to clean_q.
    task automatic predict_strip(input logic [BYTE_W-1:0] b, input logic l);
        if (!strip_on)
        begin
            if (slash_pending)
            begin
                emit(CH_SLASH, 1'b0);
            end
            slash_pending = 1'b0;
            mode_now = MODE_NORMAL;
            emit(b, l);
        end
        else
        begin
            case (mode_now)
                MODE_STR, MODE_STR_ESC:
                begin
                    if (mode_now == MODE_STR_ESC && (b == CH_QUOTE || b == CH_BSLASH))
                    begin
                        mode_now = MODE_STR;
                    end
                    else
                    begin
                        mode_now = str_next(b);
                    end
                    emit(b, l);
                end
                MODE_BLOCK, MODE_BLOCK_STAR:
                begin
                    if (b == CH_NUL)
                    begin
                        mode_now = MODE_NORMAL;
                        emit(b, l);
                    end
                    else
                    begin
                        if (b == CH_STAR)
                        begin
                            mode_now = MODE_BLOCK_STAR;
                        end
                        else if (mode_now == MODE_BLOCK_STAR && b == CH_SLASH)
                        begin
                            mode_now = MODE_NORMAL;
                        end
                        else
                        begin
                            mode_now = MODE_BLOCK;
                        end
                        emit(CH_SPACE, l);
                    end
                end
                MODE_LINE:
                begin
                    if (b == CH_NL || b == CH_NUL)
                    begin
                        mode_now = MODE_NORMAL;
                        emit(b, l);
                    end
                    else
                    begin
                        emit(CH_SPACE, l);
                    end
                end
                default:
                begin
                    mode_now = MODE_NORMAL;
                    if (slash_pending && (b == CH_STAR || b == CH_SLASH))
                    begin
                        slash_pending = 1'b0;
                        mode_now = (b == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                        emit(CH_SPACE, 1'b0);
                        emit(CH_SPACE, l);
                    end
                    else if (!slash_pending && b == CH_SLASH)
                    begin
                        // hold for lookahead unless the text ends here
                        if (l)
                        begin
                            emit(b, 1'b1);
                        end
                        else
                        begin
                            slash_pending = 1'b1;
                        end
                    end
                    else
                    begin
                        if (slash_pending)
                        begin
                            slash_pending = 1'b0;
                            emit(CH_SLASH, 1'b0);
                        end
                        if (b == CH_QUOTE)
                        begin
                            mode_now = MODE_STR;
                        end
                        emit(b, l);
                    end
                end
            endcase
        end
        if (l)
        begin
            mode_now = MODE_NORMAL;
            slash_pending = 1'b0;
        end
    endtask

    // Offer one byte in the current burst; predict on its transaction.
    task automatic offer(input logic [BYTE_W-1:0] b, input logic l,
                         input logic typed, input beat_t want);
        int gap;
        int mark;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                src_if.valid <= 1'b0;
                @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        src_if.valid   <= 1'b1;
        src_if.in_byte <= b;
        src_if.in_last <= l;
        do @(posedge clk); while (!src_if.ready);
        mark = clean_q.size();
        predict_strip(b, l);
        if (typed)
        begin
            while (clean_q.size() > mark)
            begin
                clean_q.delete(clean_q.size() - 1);
            end
            clean_q.insert(clean_q.size(), want);
        end
        bytes_sent++;
    endtask

    task automatic src_stop();
        @(negedge clk);
        src_if.valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected byte, then let the pipe empty.
    task automatic settle();
        src_stop();
        while (clean_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_strip(input logic v);
        @(negedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.strip_enable <= v;
        do @(posedge clk); while (!cfg_if.ready);
        strip_on = v;
        strip_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic put_text(input logic [BYTE_W-1:0] b);
        beat_t nb;
        nb.data = b;
        nb.last = 1'b0;
        text_q.insert(text_q.size(), nb);
    endtask

    // bytes that steer the scanner, mixed with printable text
    function automatic logic [BYTE_W-1:0] filler();
        case ($urandom_range(0, 15))
            0, 1:    return CH_STAR;
            2, 3:    return CH_SLASH;
            4:       return CH_NL;
            5:       return CH_QUOTE;
            6:       return CH_BSLASH;
            7:       return CH_NUL;
            8:       return CH_SPACE;
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // Build one text from comments, strings, plain runs and noise.
    task automatic make_text();
        int tokens;
        int len;
        tokens = $urandom_range(1, 8);
        repeat (tokens)
        begin
            len = $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    put_text(CH_SLASH);
                    put_text(CH_STAR);
                    repeat (len) put_text(filler());
                    if ($urandom_range(0, 7) != 0)
                    begin
                        put_text(CH_STAR);
                        put_text(CH_SLASH);
                    end
                end
                2, 3:
                begin
                    put_text(CH_SLASH);
                    put_text(CH_SLASH);
                    repeat (len) put_text(filler());
                    put_text(CH_NL);
                end
                4, 5:
                begin
                    put_text(CH_QUOTE);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            put_text(CH_BSLASH);
                        end
                        put_text(filler());
                    end
                    put_text(CH_QUOTE);
                end
                6, 7:    repeat (len + 1) put_text(8'($urandom_range(8'h20, 8'h7E)));
                8:       repeat (len + 1) put_text(8'($urandom_range(0, 255)));
                default:
                begin
                    put_text(CH_SLASH);
                    put_text(filler());
                end
            endcase
        end
        text_q[text_q.size() - 1].last = 1'b1;
    endtask

    // check each output transaction against the oldest expected byte
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && dst_if.valid && dst_if.ready)
        begin
            if (clean_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %h last %b",
                                          dst_if.out_byte, dst_if.out_last));
            end
            else
            begin
                want = clean_q.pop_front();
                if (dst_if.out_byte !== want.data)
                begin
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              dst_if.out_byte, want.data));
                end
                if (dst_if.out_last !== want.last)
                begin
                    report_mismatch($sformatf("out_last %b, want %b on byte %h",
                                              dst_if.out_last, want.last, want.data));
                end
                beats_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)
            || (cfg_if.valid && cfg_if.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("stalled with %0d bytes outstanding", clean_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls at a rate redrawn from 0/30/60/85 percent, long hold-off on request
    initial
    begin
        int stall_pct;
        int hold_left;
        int tick;
        stall_pct = 0;
        hold_left = 0;
        tick = 0;
        dst_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (tick % 200 == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                dst_if.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 79;
                hold_count++;
                dst_if.ready <= 1'b0;
            end
            else
            begin
                dst_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        beat_t nxt;
        beat_t want;
        logic  phase_strip [N_PHASES];
        int    phase_len [N_PHASES];

        phase_strip = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_len   = '{450, 200, 450, 60, 190};

        script = '{
            '{8'hFF,     1'b0, 1'b1, 8'hFF,    1'b0},  // first byte after reset
            '{CH_QUOTE,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},  // slash inside a string
            '{CH_BSLASH, 1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_QUOTE,  1'b0, 1'b0, CH_NUL,   1'b0},  // escaped quote
            '{CH_BSLASH, 1'b0, 1'b0, CH_NUL,   1'b0},
            '{8'h6E,     1'b0, 1'b0, CH_NUL,   1'b0},  // backslash before plain byte
            '{CH_QUOTE,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{8'h78,     1'b0, 1'b0, CH_NUL,   1'b0},  // lone slash released
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_STAR,   1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_NL,     1'b0, 1'b1, CH_SPACE, 1'b0},  // newline blanked in block
            '{CH_STAR,   1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{8'h80,     1'b0, 1'b1, CH_SPACE, 1'b0},
            '{CH_NL,     1'b0, 1'b1, CH_NL,    1'b0},  // newline ends line comment
            '{CH_QUOTE,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_NL,     1'b0, 1'b1, CH_NL,    1'b0},  // newline ends string
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_STAR,   1'b0, 1'b0, CH_NUL,   1'b0},
            '{CH_NUL,    1'b0, 1'b1, CH_NUL,   1'b0},  // NUL ends block comment
            '{CH_SLASH,  1'b0, 1'b0, CH_NUL,   1'b0},
            '{8'h7F,     1'b1, 1'b0, CH_NUL,   1'b0},  // held slash, then end of text
            '{CH_SLASH,  1'b1, 1'b1, CH_SLASH, 1'b1}   // slash as final byte
        };

        errors = 0;
        bytes_sent = 0;
        beats_checked = 0;
        strip_writes = 0;
        hold_count = 0;
        drain_pauses = 0;
        burst_left = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        strip_on = STRIP_RESET;
        mode_now = MODE_NORMAL;
        slash_pending = 1'b0;

        rst_n = 1'b0;
        src_if.valid = 1'b0;
        src_if.in_byte = '0;
        src_if.in_last = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.strip_enable = STRIP_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_SCRIPT; i++)
        begin
            want.data = script[i].want_data;
            want.last = script[i].want_last;
            offer(script[i].data, script[i].last, script[i].typed, want);
        end

        want = '0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            // leave a slash held across the write so a disable must flush it
            if (strip_on)
            begin
                offer(CH_SLASH, 1'b0, 1'b0, want);
            end
            settle();
            write_strip(phase_strip[p]);
            for (int k = 0; k < phase_len[p]; k++)
            begin
                if (text_q.size() == 0)
                begin
                    make_text();
                end
                nxt = text_q.pop_front();
                if (p == 2 && k == 100)
                begin
                    hold_req = 1'b1;
                    burst_left = 300;
                end
                if (p == 2 && k == 250)
                begin
                    src_stop();
                    while (clean_q.size() != 0)
                    begin
                        @(posedge clk);
                    end
                    drain_pauses++;
                end
                offer(nxt.data, nxt.last, 1'b0, want);
            end
        end

        src_stop();
        while (clean_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES + 2) @(posedge clk);

        $display("stripper run: %0d bytes in, %0d bytes out checked, %0d strip_enable writes",
                 bytes_sent, beats_checked, strip_writes);
        $display("receiver hold-offs: %0d, sender drain pauses: %0d, mismatches: %0d",
                 hold_count, drain_pauses, errors);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### json_comment_stripper.f
rtl/core/jcs_pkg.sv
rtl/core/jcs_if.sv
rtl/core/jcs_step.sv
rtl/core/jcs_out_fifo.sv
rtl/core/json_comment_stripper.sv
dv/json_comment_stripper_test.sv
